@@ src/ffd_pkg.sv @@
// Shared types, constants and the CRC-16 byte step for the frame deframer.
// No dependencies; used by ffd_front, ffd_back and the top level.
package ffd_pkg;

  localparam logic [7:0]  START_BYTE = 8'h55;
  localparam logic [7:0]  END_BYTE   = 8'hAA;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_TOP    = 16'h8000;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
  } ffd_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN,
    ST_DECIDE,
    ST_ERR,
    ST_WRD,
    ST_FIN,
    ST_PUSH
  } ffd_state_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/ffd_front.sv @@
// Input side of the deframer: accepts bytes, flags end markers and queues them.
// Depends on ffd_pkg.
module ffd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              q_valid,
  output ffd_pkg::ffd_item_t q_item,
  input  logic              pop
);

  ffd_pkg::ffd_item_t     fifo [ffd_pkg::QDEPTH];
  logic [ffd_pkg::QPW-1:0] wr_ptr;
  logic [ffd_pkg::QPW-1:0] rd_ptr;
  logic [ffd_pkg::QPW:0]   fill;
  logic                    push;

  assign in_stall = (fill == (ffd_pkg::QPW + 1)'(ffd_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign q_item   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr].data   <= rx_byte;
      fifo[wr_ptr].is_end <= (rx_byte == ffd_pkg::END_BYTE);
    end
  end

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue popped while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (ffd_pkg::QPW + 1)'(ffd_pkg::QDEPTH))
    else $error("queue fill beyond depth");

endmodule

@@ src/ffd_back.sv @@
// Window engine of the deframer: circular byte window, marker check, CRC walk
// and word emission through an output register. Depends on ffd_pkg.
module ffd_back #(
  parameter int WORD_COUNT = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ffd_pkg::ffd_item_t q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        word_value,
  output logic [3:0]         word_index,
  output logic               last_word,
  output logic               crc_error
);

  localparam int FrameLen = 4 * WORD_COUNT + 4;
  localparam int CrcPos   = 4 * WORD_COUNT + 1;
  localparam int AW       = $clog2(FrameLen);
  localparam int WIW      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW + 1)'(FrameLen)) begin
      s = s - (AW + 1)'(FrameLen);
    end
    return s[AW-1:0];
  endfunction

  ffd_pkg::ffd_state_t state, state_next;

  logic [7:0]     mem [FrameLen];
  logic [7:0]     rd_data;
  logic [AW-1:0]  head;
  logic [AW-1:0]  count;
  logic [AW-1:0]  off;
  logic [AW-1:0]  rd_off_d;
  logic           rd_vld_d;
  logic           asm_vld;
  logic           cur_end;
  logic [15:0]    crc;
  logic [15:0]    rx_crc;
  logic [1:0]     byte_ix;
  logic [WIW-1:0] word_ix;
  logic [31:0]    word_acc;

  logic           wr_en;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic           load_out;
  logic           out_free;
  logic           window_full;
  logic           match;
  logic           is_last;

  assign out_free    = !out_valid || !out_stall;
  assign window_full = (count == AW'(FrameLen - 1));
  assign match       = (rd_data == ffd_pkg::START_BYTE) && cur_end;
  assign is_last     = (word_ix == WIW'(WORD_COUNT - 1));
  assign wr_addr     = wrap_add(head, count);

  always_comb begin
    state_next = state;
    case (state)
      ffd_pkg::ST_IDLE: begin
        if (q_valid && window_full) state_next = ffd_pkg::ST_CHECK;
      end
      ffd_pkg::ST_CHECK: begin
        state_next = match ? ffd_pkg::ST_WALK : ffd_pkg::ST_IDLE;
      end
      ffd_pkg::ST_WALK: begin
        if (off == AW'(FrameLen - 2)) state_next = ffd_pkg::ST_DRAIN;
      end
      ffd_pkg::ST_DRAIN:  state_next = ffd_pkg::ST_DECIDE;
      ffd_pkg::ST_DECIDE: begin
        state_next = (rx_crc == crc) ? ffd_pkg::ST_WRD : ffd_pkg::ST_ERR;
      end
      ffd_pkg::ST_ERR: begin
        if (out_free) state_next = ffd_pkg::ST_IDLE;
      end
      ffd_pkg::ST_WRD: begin
        if (byte_ix == 2'd3) state_next = ffd_pkg::ST_FIN;
      end
      ffd_pkg::ST_FIN:    state_next = ffd_pkg::ST_PUSH;
      ffd_pkg::ST_PUSH: begin
        if (out_free) state_next = is_last ? ffd_pkg::ST_IDLE : ffd_pkg::ST_WRD;
      end
      default:            state_next = ffd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = wrap_add(head, off);
    load_out = 1'b0;
    case (state)
      ffd_pkg::ST_IDLE: begin
        pop     = q_valid;
        wr_en   = q_valid;
        rd_en   = q_valid;
        rd_addr = head;
      end
      ffd_pkg::ST_WALK,
      ffd_pkg::ST_WRD: begin
        rd_en = 1'b1;
      end
      ffd_pkg::ST_ERR,
      ffd_pkg::ST_PUSH: begin
        load_out = out_free;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffd_pkg::ST_IDLE;
      head      <= '0;
      count     <= '0;
      rd_vld_d  <= 1'b0;
      asm_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld_d <= (state == ffd_pkg::ST_WALK);
      asm_vld  <= (state == ffd_pkg::ST_WRD);
      if (state == ffd_pkg::ST_IDLE && q_valid && !window_full) begin
        count <= count + 1'b1;
      end
      if (state == ffd_pkg::ST_CHECK && !match) begin
        head <= wrap_add(head, AW'(1));
      end
      if (load_out && (state == ffd_pkg::ST_ERR || is_last)) begin
        count <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_item.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    rd_off_d <= off;
    if (state == ffd_pkg::ST_IDLE) begin
      cur_end <= q_item.is_end;
    end
    case (state)
      ffd_pkg::ST_CHECK:  off <= '0;
      ffd_pkg::ST_DECIDE: off <= AW'(1);
      ffd_pkg::ST_WALK,
      ffd_pkg::ST_WRD:    off <= off + 1'b1;
      default:            off <= off;
    endcase
    if (state == ffd_pkg::ST_CHECK) begin
      crc <= ffd_pkg::CRC_INIT;
    end else if (rd_vld_d && rd_off_d < AW'(CrcPos)) begin
      crc <= ffd_pkg::crc16_byte(crc, rd_data);
    end
    if (rd_vld_d && rd_off_d == AW'(CrcPos)) begin
      rx_crc[7:0] <= rd_data;
    end
    if (rd_vld_d && rd_off_d == AW'(CrcPos + 1)) begin
      rx_crc[15:8] <= rd_data;
    end
    if (state == ffd_pkg::ST_DECIDE) begin
      byte_ix <= '0;
      word_ix <= '0;
    end else begin
      if (state == ffd_pkg::ST_WRD) begin
        byte_ix <= byte_ix + 1'b1;
      end
      if (state == ffd_pkg::ST_PUSH && load_out) begin
        word_ix <= word_ix + 1'b1;
      end
    end
    if (asm_vld) begin
      word_acc <= {rd_data, word_acc[31:8]};
    end
    if (load_out) begin
      if (state == ffd_pkg::ST_ERR) begin
        word_value <= '0;
        word_index <= '0;
        last_word  <= 1'b1;
        crc_error  <= 1'b1;
      end else begin
        word_value <= word_acc;
        word_index <= 4'(word_ix);
        last_word  <= is_last;
        crc_error  <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= AW'(FrameLen - 1))
    else $error("window count beyond frame length");
  a_walk_full: assert property (@(posedge clk) disable iff (rst)
    (state == ffd_pkg::ST_WALK || state == ffd_pkg::ST_WRD) |-> window_full)
    else $error("frame walk on a window that is not full");
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && crc_error) |-> (last_word && word_value == 32'h0 && word_index == 4'h0))
    else $error("malformed error result");

endmodule

@@ src/feedback_frame_deframer_crc16.sv @@
// Top level of the feedback frame deframer with CRC-16/CCITT-FALSE check.
// Depends on ffd_pkg, ffd_front and ffd_back.
//
// Input channel: rx_byte with in_valid / in_stall; a transfer happens on a
// rising edge with in_valid high and in_stall low. Output channel: word_value,
// word_index, last_word and crc_error with out_valid / out_stall, same rule.
// Bytes fill a window one frame long (4*WORD_COUNT+4 bytes) held in a memory
// with one write and one read port. A byte is registered in the queue and can
// leave it from the cycle after its transfer. Until the window is full the
// engine stores each byte as it leaves the queue; once full, each byte takes
// two steps in the window engine (store with the oldest byte read back, then
// marker check). A byte that completes a framed window starts a walk over the
// memory, one byte a cycle, followed by a drain step and the CRC decision;
// each payload word then takes four reads, one merge and one load, the load
// waiting for a free output register, as does the error load after a bad CRC.
// The single read port serialises these steps. A two-entry queue decouples
// the input from the window engine, so bytes are taken during a walk until
// the queue fills. Sync reset (rst) empties the queue, the window and the
// output register; window contents need no clearing. While out_stall is high
// the result held stays unchanged and the engine waits on its next result.
module feedback_frame_deframer_crc16 #(
  parameter int WORD_COUNT = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] word_value,
  output logic [3:0]  word_index,
  output logic        last_word,
  output logic        crc_error
);

  logic               q_valid;
  ffd_pkg::ffd_item_t q_item;
  logic               pop;

  ffd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop)
  );

  ffd_back #(
    .WORD_COUNT (WORD_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_value (word_value),
    .word_index (word_index),
    .last_word  (last_word),
    .crc_error  (crc_error)
  );

endmodule
